@@ rtl/ptc_pkg.sv @@
// shared types, constants and the cordic angle table of the posture tilt classifier
package ptc_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int RING_LEN          = 8;
	localparam int RING_IDX_W        = 3;
	localparam int CORDIC_STEPS      = 16;
	localparam int STEP_W            = 4;

	typedef logic signed [15:0] accel_t;
	typedef logic signed [16:0] angle_t;
	typedef logic signed [15:0] tilt_t;
	typedef logic        [13:0] drop_t;
	typedef logic        [11:0] offset_t;
	typedef logic        [1:0]  class_t;
	typedef logic        [1:0]  cfg_idx_t;
	typedef logic        [16:0] cfg_data_t;

	localparam angle_t NECK_OFFSET = 17'sd22784;
	localparam int     TILT_LIMIT  = 23040;

	localparam class_t CLASS_GOOD      = 2'd0;
	localparam class_t CLASS_BAD       = 2'd1;
	localparam class_t CLASS_IMPROVING = 2'd2;

	localparam cfg_idx_t CFG_BASELINE = 2'd0;
	localparam cfg_idx_t CFG_DROP     = 2'd1;
	localparam cfg_idx_t CFG_OFFSET   = 2'd2;

	localparam angle_t  BASELINE_RST = 17'sd0;
	localparam drop_t   DROP_RST     = 14'd1280;
	localparam offset_t OFFSET_RST   = 12'd256;

	// status of an iterative unit back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// atan(2^-i) in degrees * 65536, rounded to nearest
	function automatic logic [21:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [21:0] v;
		case (i)
			4'd0:    v = 22'd2949120;
			4'd1:    v = 22'd1740967;
			4'd2:    v = 22'd919879;
			4'd3:    v = 22'd466945;
			4'd4:    v = 22'd234379;
			4'd5:    v = 22'd117304;
			4'd6:    v = 22'd58666;
			4'd7:    v = 22'd29335;
			4'd8:    v = 22'd14668;
			4'd9:    v = 22'd7334;
			4'd10:   v = 22'd3667;
			4'd11:   v = 22'd1833;
			4'd12:   v = 22'd917;
			4'd13:   v = 22'd458;
			4'd14:   v = 22'd229;
			default: v = 22'd115;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/ptc_ifs.sv @@
// valid/ready channels for samples in and posture results out
interface ptc_in_if;
	logic            valid;
	logic            ready;
	logic            restart;
	ptc_pkg::accel_t accel_x;
	ptc_pkg::accel_t accel_y;
	ptc_pkg::accel_t accel_z;

	modport source (output valid, restart, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, restart, accel_x, accel_y, accel_z, output ready);
endinterface

interface ptc_out_if;
	logic            valid;
	logic            ready;
	ptc_pkg::angle_t neck_angle;
	logic            bad_flag;
	ptc_pkg::class_t posture_class;

	modport source (output valid, neck_angle, bad_flag, posture_class, input ready);
	modport sink   (input valid, neck_angle, bad_flag, posture_class, output ready);
endinterface

@@ rtl/ptc_isqrt.sv @@
// digit-by-digit integer square root, one result bit per cycle
module ptc_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         radicand,
	output logic [15:0]         root,
	output ptc_pkg::unit_stat_t stat
);
	import ptc_pkg::*;

	logic [31:0]       n_q;
	logic [31:0]       r_q;
	logic [STEP_W-1:0] k_q;
	logic              busy_q;
	logic              done_q;
	logic [31:0]       bit_w;
	logic [32:0]       trial;
	logic              take;

	assign bit_w = 32'(1) << {k_q, 1'b0};
	assign trial = {1'b0, r_q} + {1'b0, bit_w};
	assign take  = {1'b0, n_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= STEP_W'(CORDIC_STEPS - 1);
			end else if (busy_q) begin
				k_q <= k_q - 1'b1;
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				n_q <= n_q - trial[31:0];
				r_q <= (r_q >> 1) + bit_w;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign root      = r_q[15:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && k_q != '0) |-> !start)
		else $error("isqrt restarted while busy");

endmodule

@@ rtl/ptc_cordic.sv @@
// vectoring cordic, one micro-rotation per cycle, angle out in degrees * 256
module ptc_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         mag,
	input  ptc_pkg::accel_t     xin,
	output ptc_pkg::tilt_t      tilt,
	output ptc_pkg::unit_stat_t stat
);
	import ptc_pkg::*;

	logic signed [32:0] cx_q;
	logic signed [32:0] cy_q;
	logic signed [24:0] acc_q;
	logic [STEP_W-1:0]  i_q;
	logic               zero_q;
	logic               busy_q;
	logic               done_q;
	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [24:0] step_ang;
	logic signed [24:0] rounded;
	logic signed [24:0] clamped;

	assign dx       = cy_q >>> i_q;
	assign dy       = cx_q >>> i_q;
	assign step_ang = signed'(25'(atan_lut(i_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q   <= signed'(33'(mag) << 14);
			cy_q   <= 33'(xin) <<< 14;
			acc_q  <= '0;
			zero_q <= (mag == '0) && (xin == '0);
		end else if (busy_q) begin
			// rotate toward the x axis
			if (!cy_q[32]) begin
				cx_q  <= cx_q + dx;
				cy_q  <= cy_q - dy;
				acc_q <= acc_q + step_ang;
			end else begin
				cx_q  <= cx_q - dx;
				cy_q  <= cy_q + dy;
				acc_q <= acc_q - step_ang;
			end
		end
	end

	assign rounded = (acc_q + 25'sd128) >>> 8;

	always_comb begin
		if (rounded > 25'(TILT_LIMIT))
			clamped = 25'(TILT_LIMIT);
		else if (rounded < -25'(TILT_LIMIT))
			clamped = -25'(TILT_LIMIT);
		else
			clamped = rounded;
	end

	assign tilt      = zero_q ? '0 : 16'(clamped);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/posture_tilt_classifier.sv @@
// posture tilt classifier: sequencer, squares, angle ring and classification
// a new sample is accepted only in the idle state, once the previous result has gone into the output register
// each sample passes the two squares, the 16-step square root, the 16-step cordic, the ring write and the ring sum
// a restart item goes from idle straight to the done state and skips the datapath
// reset clears the ring to zero, the run counter and flag, and loads default registers
module posture_tilt_classifier #(
	parameter int HistoryDepth = ptc_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	ptc_in_if.sink              sample,
	ptc_out_if.source           result,
	input  logic                cfg_we,
	input  ptc_pkg::cfg_idx_t   cfg_idx,
	input  ptc_pkg::cfg_data_t  cfg_data
);
	import ptc_pkg::*;

	localparam int CntW = $clog2(HistoryDepth + 1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SQY    = 8'b0000_0010,
		ST_SQZ    = 8'b0000_0100,
		ST_ROOT   = 8'b0000_1000,
		ST_CORDIC = 8'b0001_0000,
		ST_WRITE  = 8'b0010_0000,
		ST_SUM    = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	angle_t  baseline_q;
	drop_t   drop_q;
	offset_t offset_q;

	accel_t x_q;
	accel_t y_q;
	accel_t z_q;
	logic   restart_q;

	logic signed [31:0] sq_prod;
	accel_t             sq_op;
	logic [31:0]        sumsq_q;
	logic               root_go_q;
	logic               cordic_go_q;
	logic [15:0]        root;
	tilt_t              tilt;
	unit_stat_t         root_stat;
	unit_stat_t         cordic_stat;

	angle_t                 angle_q;
	angle_t                 ring_q [RING_LEN];
	logic [RING_IDX_W-1:0]  ptr_q;
	logic [RING_IDX_W-1:0]  sidx_q;
	logic signed [19:0]     sum_q;

	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] cnt_d;
	logic            hf_q;
	logic            hf_d;
	class_t          cls_d;

	logic        out_valid_q;
	angle_t      out_angle_q;
	logic        out_bad_q;
	class_t      out_cls_q;

	logic               accept;
	logic               fire;
	logic signed [18:0] bad_thr;
	logic               is_low;
	logic signed [21:0] lhs8;
	logic signed [21:0] rhs8;

	assign accept = sample.valid && sample.ready;
	assign fire   = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= BASELINE_RST;
			drop_q     <= DROP_RST;
			offset_q   <= OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_BASELINE: baseline_q <= signed'(cfg_data);
				CFG_DROP:     drop_q     <= cfg_data[13:0];
				CFG_OFFSET:   offset_q   <= cfg_data[11:0];
				default:      ;
			endcase
		end
	end

	// one multiplier shared by both squares
	assign sq_op   = (state_q == ST_SQY) ? y_q : z_q;
	assign sq_prod = sq_op * sq_op;

	ptc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_go_q),
		.radicand (sumsq_q),
		.root     (root),
		.stat     (root_stat)
	);

	ptc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_go_q),
		.mag    (root),
		.xin    (x_q),
		.tilt   (tilt),
		.stat   (cordic_stat)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = sample.restart ? ST_DONE : ST_SQY;
			ST_SQY:    state_d = ST_SQZ;
			ST_SQZ:    state_d = ST_ROOT;
			ST_ROOT:   if (root_stat.done) state_d = ST_CORDIC;
			ST_CORDIC: if (cordic_stat.done) state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_SUM;
			ST_SUM:    if (sidx_q == RING_IDX_W'(RING_LEN - 1)) state_d = ST_DONE;
			ST_DONE:   if (fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// classification of the new angle against baseline and ring average
	assign bad_thr = 19'(baseline_q) - signed'(19'(drop_q));
	assign is_low  = 19'(angle_q) < bad_thr;
	assign lhs8    = 22'(angle_q) <<< 3;
	assign rhs8    = 22'(sum_q) + signed'(22'({offset_q, 3'b000}));

	always_comb begin
		cnt_d = cnt_q;
		hf_d  = hf_q;
		cls_d = CLASS_GOOD;
		if (!hf_q) begin
			if (is_low) begin
				if (cnt_q < CntW'(HistoryDepth))
					cnt_d = cnt_q + 1'b1;
			end else begin
				cnt_d = '0;
			end
			if (cnt_d >= CntW'(HistoryDepth)) begin
				hf_d  = 1'b1;
				cls_d = CLASS_BAD;
			end
		end else if (angle_q > baseline_q) begin
			hf_d  = 1'b0;
			cnt_d = '0;
		end else if (lhs8 > rhs8) begin
			cls_d = CLASS_IMPROVING;
		end else begin
			cls_d = CLASS_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_go_q   <= 1'b0;
			cordic_go_q <= 1'b0;
			ptr_q       <= '0;
			sidx_q      <= '0;
			cnt_q       <= '0;
			hf_q        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < RING_LEN; i++)
				ring_q[i] <= '0;
		end else begin
			state_q     <= state_d;
			root_go_q   <= (state_q == ST_SQZ);
			cordic_go_q <= (state_q == ST_ROOT) && root_stat.done;
			if (accept && sample.restart) begin
				for (int i = 0; i < RING_LEN; i++)
					ring_q[i] <= baseline_q;
				ptr_q <= '0;
				cnt_q <= '0;
				hf_q  <= 1'b0;
			end
			if (state_q == ST_WRITE) begin
				ring_q[ptr_q] <= angle_q;
				ptr_q         <= ptr_q + 1'b1;
				sidx_q        <= '0;
			end
			if (state_q == ST_SUM)
				sidx_q <= sidx_q + 1'b1;
			if (fire && !restart_q) begin
				cnt_q <= cnt_d;
				hf_q  <= hf_d;
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// sample, datapath and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			restart_q <= sample.restart;
			x_q       <= sample.accel_x;
			y_q       <= sample.accel_y;
			z_q       <= sample.accel_z;
		end
		if (state_q == ST_SQY)
			sumsq_q <= 32'(unsigned'(sq_prod));
		if (state_q == ST_SQZ)
			sumsq_q <= sumsq_q + 32'(unsigned'(sq_prod));
		if (state_q == ST_CORDIC && cordic_stat.done)
			angle_q <= 17'(tilt) + NECK_OFFSET;
		if (state_q == ST_WRITE)
			sum_q <= '0;
		if (state_q == ST_SUM)
			sum_q <= sum_q + 20'(ring_q[sidx_q]);
		if (fire) begin
			if (restart_q) begin
				out_angle_q <= baseline_q;
				out_bad_q   <= 1'b0;
				out_cls_q   <= CLASS_GOOD;
			end else begin
				out_angle_q <= angle_q;
				out_bad_q   <= hf_d;
				out_cls_q   <= cls_d;
			end
		end
	end

	assign sample.ready         = (state_q == ST_IDLE);
	assign result.valid         = out_valid_q;
	assign result.neck_angle    = out_angle_q;
	assign result.bad_flag      = out_bad_q;
	assign result.posture_class = out_cls_q;

	a_flag_implies_full_run: assert property (@(posedge clk) disable iff (!arst_n)
		hf_q |-> cnt_q == CntW'(HistoryDepth))
		else $error("bad flag set without a full low run");

	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(HistoryDepth))
		else $error("run counter beyond history depth");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_root_to_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT && root_stat.done) |=> cordic_go_q && state_q == ST_CORDIC)
		else $error("cordic not started after square root");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(root_stat.busy && cordic_stat.busy))
		else $error("square root and cordic busy together");

endmodule

@@ tb/sv/tb_posture_tilt_classifier.sv @@
// self-checking testbench for the posture tilt classifier with random handshake idling
module tb_posture_tilt_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import ptc_pkg::*;

	localparam int       RUN_LIMIT  = 1000000;
	localparam int       HOLD_LEN   = 400;
	localparam int       DRAIN_WAIT = 60;
	localparam int       LOW_RUN    = HISTORY_DEPTH_DEF;
	localparam cfg_idx_t CFG_UNUSED = 2'd3;
	localparam accel_t   AX_MIN     = 16'sh8000;
	localparam accel_t   AX_MAX     = 16'sh7fff;
	localparam real      PI         = 3.14159265358979;

	typedef struct packed {
		logic   restart;
		accel_t x;
		accel_t y;
		accel_t z;
	} sample_t;

	typedef struct packed {
		angle_t neck;
		logic   flagged;
		class_t cls;
	} posture_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_idx;
	cfg_data_t cfg_data;

	ptc_in_if  sample_ch ();
	ptc_out_if result_ch ();

	posture_tilt_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// atan(2^-i) in degrees * 65536
	longint atan_deg16 [CORDIC_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	// predictor state and register copies
	angle_t     hist_ring [RING_LEN];
	logic [2:0] hist_ptr;
	int         low_run;
	logic       head_fwd;
	class_t     cur_class;
	angle_t     cur_angle;
	angle_t     cfg_base;
	drop_t      cfg_drop;
	offset_t    cfg_off;

	posture_t pending_postures [$];
	int       mismatches;
	int       items_sent;
	int       cycle_count;
	bit       no_idle;
	bit       rx_hold;
	event     hold_start;

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned rem, r, b;
		rem = n;
		r   = 0;
		b   = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic angle_t neck_angle_of(input accel_t ax, input accel_t ay, input accel_t az);
		longint unsigned mag;
		longint cx, cy, dx, dy, acc, q;
		mag = root_floor(longint'(ay) * longint'(ay) + longint'(az) * longint'(az));
		q   = 0;
		if (mag != 0 || ax != 0) begin
			cx  = longint'(mag) * 16384;
			cy  = longint'(ax) * 16384;
			acc = 0;
			// vectoring mode: drive y to zero, accumulate the angle
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx  = cx + dx;
					cy  = cy - dy;
					acc = acc + atan_deg16[i];
				end else begin
					cx  = cx - dx;
					cy  = cy + dy;
					acc = acc - atan_deg16[i];
				end
			end
			q = (acc + 128) >>> 8;
			if (q > TILT_LIMIT)
				q = TILT_LIMIT;
			if (q < -TILT_LIMIT)
				q = -TILT_LIMIT;
		end
		return angle_t'(q + longint'(NECK_OFFSET));
	endfunction

	function automatic posture_t predict_posture(input sample_t s);
		angle_t a;
		longint ring_sum;
		if (s.restart) begin
			foreach (hist_ring[i])
				hist_ring[i] = cfg_base;
			hist_ptr  = '0;
			low_run   = 0;
			head_fwd  = 1'b0;
			cur_class = CLASS_GOOD;
			cur_angle = cfg_base;
		end else begin
			a = neck_angle_of(s.x, s.y, s.z);
			hist_ring[hist_ptr] = a;
			hist_ptr  = hist_ptr + 3'd1;
			cur_angle = a;
			if (!head_fwd) begin
				if (longint'(a) < longint'(cfg_base) - longint'(cfg_drop)) begin
					if (low_run < LOW_RUN)
						low_run++;
				end else begin
					low_run = 0;
				end
				if (low_run >= LOW_RUN) begin
					head_fwd  = 1'b1;
					cur_class = CLASS_BAD;
				end else begin
					cur_class = CLASS_GOOD;
				end
			end else begin
				ring_sum = 0;
				foreach (hist_ring[i])
					ring_sum += longint'(hist_ring[i]);
				if (a > cfg_base) begin
					head_fwd  = 1'b0;
					low_run   = 0;
					cur_class = CLASS_GOOD;
				end else if (longint'(a) * RING_LEN >
						ring_sum + RING_LEN * longint'(cfg_off)) begin
					cur_class = CLASS_IMPROVING;
				end else begin
					cur_class = CLASS_BAD;
				end
			end
		end
		return '{cur_angle, head_fwd, cur_class};
	endfunction

	// sample tilted by deg degrees at a random magnitude and heading
	function automatic sample_t tilted_sample(input real deg);
		sample_t s;
		real r, phi, rad, h;
		if (deg > 90.0)
			deg = 90.0;
		if (deg < -90.0)
			deg = -90.0;
		r   = $urandom_range(1500, 32767);
		phi = $urandom_range(0, 359) * PI / 180.0;
		rad = deg * PI / 180.0;
		h   = r * $cos(rad);
		s.restart = 1'b0;
		s.x = accel_t'($rtoi(r * $sin(rad)));
		s.y = accel_t'($rtoi(h * $cos(phi)));
		s.z = accel_t'($rtoi(h * $sin(phi)));
		return s;
	endfunction

	function automatic accel_t noise_axis();
		case ($urandom_range(0, 9))
			0:       return AX_MIN;
			1:       return AX_MAX;
			2:       return 16'sd0;
			default: return accel_t'(16'($urandom));
		endcase
	endfunction

	function automatic sample_t noise_sample();
		sample_t s;
		s.restart = 1'b0;
		s.x = noise_axis();
		s.y = noise_axis();
		s.z = noise_axis();
		return s;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// timeout
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// result side ready, random unless held off or in a no-idle stretch
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold)
				result_ch.ready <= 1'b0;
			else if (no_idle)
				result_ch.ready <= 1'b1;
			else
				result_ch.ready <= ($urandom_range(99) >= 28);
		end
	end

	initial begin
		rx_hold = 1'b0;
		forever begin
			@(hold_start);
			@(posedge clk);
			rx_hold = 1'b1;
			repeat (HOLD_LEN) @(posedge clk);
			rx_hold = 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		posture_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_postures.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: angle %0d flag %0b class %0d",
						result_ch.neck_angle, result_ch.bad_flag, result_ch.posture_class);
			end else begin
				want = pending_postures.pop_front();
				if (result_ch.neck_angle !== want.neck || result_ch.bad_flag !== want.flagged
						|| result_ch.posture_class !== want.cls) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected angle %0d flag %0b class %0d, got angle %0d flag %0b class %0d",
							want.neck, want.flagged, want.cls, result_ch.neck_angle,
							result_ch.bad_flag, result_ch.posture_class);
				end
			end
		end
	end

	task automatic send_sample(input sample_t s);
		int gap;
		if (!no_idle && $urandom_range(99) < 28) begin
			gap = $urandom_range(1, 60);
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.restart <= s.restart;
		sample_ch.accel_x <= s.x;
		sample_ch.accel_y <= s.y;
		sample_ch.accel_z <= s.z;
		do @(posedge clk); while (!sample_ch.ready);
		pending_postures.push_back(predict_posture(s));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_tilt(input real deg);
		if ($urandom_range(99) < 12)
			send_sample(noise_sample());
		else
			send_sample(tilted_sample(deg));
	endtask

	// drop valid and wait until every item has come back
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_postures.size() != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_BASELINE: cfg_base = angle_t'(data);
			CFG_DROP:     cfg_drop = data[13:0];
			CFG_OFFSET:   cfg_off  = data[11:0];
			default:      ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_regs(input cfg_data_t base, input cfg_data_t drop, input cfg_data_t off);
		wait_idle();
		write_reg(CFG_BASELINE, base);
		write_reg(CFG_DROP, drop);
		write_reg(CFG_OFFSET, off);
	endtask

	// default registers, zeroed ring, field extremes and the zero vector
	task automatic test_reset_values();
		send_sample('{1'b0, 16'sd0, 16'sd0, 16'sd0});
		send_sample('{1'b0, AX_MIN, 16'sd0, 16'sd0});
		send_sample('{1'b0, AX_MAX, 16'sd0, 16'sd0});
		send_sample('{1'b0, 16'sd0, AX_MIN, 16'sd0});
		send_sample('{1'b0, 16'sd0, 16'sd0, AX_MAX});
		send_sample('{1'b0, AX_MIN, AX_MIN, AX_MIN});
		send_sample('{1'b0, AX_MAX, AX_MAX, AX_MAX});
		send_sample('{1'b1, AX_MAX, AX_MIN, AX_MAX});
	endtask

	// register values beyond range, and a write to the unused index
	task automatic test_register_writes();
		wait_idle();
		write_reg(CFG_BASELINE, 17'h10000);
		send_sample('{1'b1, 16'sd0, 16'sd0, 16'sd0});
		wait_idle();
		write_reg(CFG_UNUSED, 17'h1ffff);
		write_reg(CFG_DROP, 17'h1ffff);
		write_reg(CFG_OFFSET, 17'h1ffff);
		send_sample('{1'b1, 16'sd0, 16'sd0, 16'sd0});
		send_sample('{1'b0, AX_MIN, 16'sd0, 16'sd100});
	endtask

	// low run sets the flag, then still bad, improving and full correction
	task automatic test_forward_head_run();
		set_regs(17'd22784, 17'd1280, 17'd256);
		send_sample('{1'b1, 16'sd0, 16'sd0, 16'sd0});
		repeat (LOW_RUN) send_sample(tilted_sample(-10.0));
		send_sample(tilted_sample(-10.0));
		// angle equal to the baseline is not a correction
		send_sample('{1'b0, 16'sd0, 16'sd9000, -16'sd4000});
		send_sample(tilted_sample(-2.0));
		send_sample(tilted_sample(1.0));
		send_sample(tilted_sample(-10.0));
	endtask

	// sessions: restart, good stretch, low run, then flagged samples
	task automatic test_random_sessions(input int n_items, input int burst_items);
		sample_t s;
		int stop_at, burst_end, k;
		real base_deg, drop_deg;
		stop_at   = items_sent + n_items;
		burst_end = items_sent + burst_items;
		base_deg  = (real'(int'(cfg_base)) - 22784.0) / 256.0;
		drop_deg  = real'(int'(cfg_drop)) / 256.0;
		while (items_sent < stop_at) begin
			no_idle = (items_sent < burst_end);
			s = noise_sample();
			s.restart = 1'b1;
			send_sample(s);
			k = $urandom_range(0, 6);
			repeat (k) send_tilt(base_deg - 2.0 + $urandom_range(0, 1000) / 100.0);
			k = $urandom_range(5, 12);
			repeat (k) begin
				if ($urandom_range(9) == 0)
					send_tilt(base_deg + 1.0);
				else
					send_tilt(base_deg - drop_deg - 0.5 - $urandom_range(0, 2500) / 100.0);
			end
			k = $urandom_range(3, 14);
			repeat (k) begin
				case ($urandom_range(0, 4))
					0:       send_tilt(base_deg + 0.3 + $urandom_range(0, 1000) / 100.0);
					1, 2:    send_tilt(base_deg - $urandom_range(0, 600) / 100.0);
					default: send_tilt(base_deg - drop_deg - $urandom_range(0, 3000) / 100.0);
				endcase
			end
		end
		no_idle = 1'b0;
	endtask

	// result side held off while items keep coming, so the input stalls
	task automatic test_output_backpressure();
		wait_idle();
		-> hold_start;
		repeat (12) send_tilt($urandom_range(0, 120) - 60.0);
		wait_idle();
	endtask

	task automatic test_sender_pause();
		repeat (2) begin
			repeat (6) send_tilt($urandom_range(0, 60) - 45.0);
			wait_idle();
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = CFG_BASELINE;
		cfg_data          = '0;
		sample_ch.valid   = 1'b0;
		sample_ch.restart = 1'b0;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		sample_ch.accel_z = '0;
		foreach (hist_ring[i])
			hist_ring[i] = '0;
		hist_ptr   = '0;
		low_run    = 0;
		head_fwd   = 1'b0;
		cur_class  = CLASS_GOOD;
		cur_angle  = '0;
		cfg_base   = BASELINE_RST;
		cfg_drop   = DROP_RST;
		cfg_off    = OFFSET_RST;
		mismatches = 0;
		items_sent = 0;
		no_idle    = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_register_writes();
		test_forward_head_run();
		set_regs(17'd22784, 17'd1280, 17'd256);
		test_random_sessions(350, 150);
		test_output_backpressure();
		set_regs(17'd17920, 17'd2560, 17'd0);
		test_random_sessions(280, 0);
		test_sender_pause();
		set_regs(17'd45824, 17'd0, 17'd2560);
		test_random_sessions(200, 0);
		set_regs(17'h1ff00, 17'd11520, 17'd4095);
		test_random_sessions(100, 0);
		set_regs(17'd30000, 17'd16383, 17'd128);
		test_random_sessions(150, 0);

		wait_idle();
		repeat (DRAIN_WAIT) @(negedge clk);
		mismatches += pending_postures.size();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ptc_pkg.sv
rtl/ptc_ifs.sv
rtl/ptc_isqrt.sv
rtl/ptc_cordic.sv
rtl/posture_tilt_classifier.sv
tb/sv/tb_posture_tilt_classifier.sv
